[src/dwsd_pkg.sv]
// Package for the dual window stability detector.
// Holds sizes, control types and state codes shared by the lane, merge and top files.
// No dependencies.
`default_nettype none

package dwsd_pkg;

    localparam int WINDOW         = 8;
    localparam int SAMPLE_BITS    = 12;
    localparam int LIMIT_BITS     = 12;
    localparam int SLOT_BITS      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CMP_BITS       = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);
    localparam logic [SLOT_BITS-1:0]  LAST_SLOT   = SLOT_BITS'(WINDOW - 1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LIMIT_REF = CFG_INDEX_BITS'(0),
        REG_LIMIT_OUT = CFG_INDEX_BITS'(1)
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Control from the sequencer to each lane
    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_BITS-1:0] wr_slot;
        logic                 scan_en;
        logic                 scan_first;
        logic [SLOT_BITS-1:0] scan_idx;
    } lane_ctl_t;

endpackage

`default_nettype wire

[src/dwsd_lane.sv]
// One channel lane: ring store of the window plus a max/min scanner
// that walks one entry per cycle. Depends on dwsd_pkg.
`default_nettype none

module dwsd_lane (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire dwsd_pkg::lane_ctl_t              ctl,
    input  wire logic [dwsd_pkg::SAMPLE_BITS-1:0] sample,
    output logic      [dwsd_pkg::SAMPLE_BITS-1:0] hi,
    output logic      [dwsd_pkg::SAMPLE_BITS-1:0] lo
);
    import dwsd_pkg::*;

    logic [SAMPLE_BITS-1:0] window_reg [WINDOW];
    logic [SAMPLE_BITS-1:0] window_next [WINDOW];
    logic [SAMPLE_BITS-1:0] hi_reg, hi_next;
    logic [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic [SAMPLE_BITS-1:0] rd_data;

    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            window_next[i] = window_reg[i];
            if (ctl.wr_en && (ctl.wr_slot == SLOT_BITS'(i)))
            begin
                window_next[i] = sample;
            end
        end
    end

    assign rd_data = window_reg[ctl.scan_idx];

    always_comb
    begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (ctl.scan_en)
        begin
            if (ctl.scan_first)
            begin
                hi_next = rd_data;
                lo_next = rd_data;
            end
            else
            begin
                if (rd_data > hi_reg)
                begin
                    hi_next = rd_data;
                end
                if (rd_data < lo_reg)
                begin
                    lo_next = rd_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign hi = hi_reg;
    assign lo = lo_reg;

endmodule

`default_nettype wire

[src/dwsd_merge.sv]
// Merge stage: turns both lanes' max/min into stable flags against the limits
// and holds the result item until taken. Depends on dwsd_pkg.
`default_nettype none

module dwsd_merge (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire logic [dwsd_pkg::SAMPLE_BITS-1:0] ref_hi,
    input  wire logic [dwsd_pkg::SAMPLE_BITS-1:0] ref_lo,
    input  wire logic [dwsd_pkg::SAMPLE_BITS-1:0] out_hi,
    input  wire logic [dwsd_pkg::SAMPLE_BITS-1:0] out_lo,
    input  wire logic [dwsd_pkg::LIMIT_BITS-1:0]  limit_ref,
    input  wire logic [dwsd_pkg::LIMIT_BITS-1:0]  limit_out,
    input  wire logic                             res_stall,
    output logic                                  res_valid,
    output logic                                  ref_stable,
    output logic                                  out_stable
);
    import dwsd_pkg::*;

    logic [SAMPLE_BITS-1:0] ref_spread, out_spread;
    logic                   ref_ok, out_ok;
    logic                   valid_reg, valid_next;
    logic                   ref_stable_reg, ref_stable_next;
    logic                   out_stable_reg, out_stable_next;

    // hi >= lo always, so the difference never wraps
    assign ref_spread = ref_hi - ref_lo;
    assign out_spread = out_hi - out_lo;
    assign ref_ok     = CMP_BITS'(ref_spread) <= CMP_BITS'(limit_ref);
    assign out_ok     = CMP_BITS'(out_spread) <= CMP_BITS'(limit_out);

    always_comb
    begin
        valid_next      = valid_reg;
        ref_stable_next = ref_stable_reg;
        out_stable_next = out_stable_reg;
        if (load)
        begin
            valid_next      = 1'b1;
            ref_stable_next = ref_ok;
            out_stable_next = out_ok;
        end
        else if (valid_reg && !res_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ref_stable_reg <= ref_stable_next;
        out_stable_reg <= out_stable_next;
    end

    assign res_valid  = valid_reg;
    assign ref_stable = ref_stable_reg;
    assign out_stable = out_stable_reg;

endmodule

`default_nettype wire

[src/dual_window_stability_detector.sv]
// Dual window stability detector, top level.
// Each item carries one sample per channel (reference, output voltage).
// Input channel: in_valid / in_stall with ref_sample, out_sample.
// Result channel: res_valid / res_stall with ref_stable, out_stable; one
// result per item, in order.
// Config: cfg_we writes cfg_data to register cfg_index (0 = reference limit,
// 1 = output limit, other indexes ignored); write only while idle.
// The shared slot steps before the write, so the first item after reset lands
// in slot 1; unwritten slots read as zero and take part in the spread.
// Steps: the item is written at the accept edge, the two lanes then walk the
// WINDOW entries one per cycle, and the compare step (ST_DONE) then compares
// the spreads and loads the result register once no held result is stalled.
// No new item is taken until the current item's result has been loaded.
// A new item is taken while a finished result still waits; if the receiver
// stalls, the next result waits in the compare step and in_stall stays high.
// Reset (rst_n, async low): windows and slot cleared, limits to 16, no result.
// Depends on dwsd_pkg, dwsd_lane, dwsd_merge.
`default_nettype none

module dual_window_stability_detector (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [dwsd_pkg::SAMPLE_BITS-1:0]    ref_sample,
    input  wire logic [dwsd_pkg::SAMPLE_BITS-1:0]    out_sample,
    output logic                                     res_valid,
    input  wire logic                                res_stall,
    output logic                                     ref_stable,
    output logic                                     out_stable,
    input  wire logic                                cfg_we,
    input  wire logic [dwsd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [dwsd_pkg::LIMIT_BITS-1:0]     cfg_data
);
    import dwsd_pkg::*;

    state_t                 state_reg, state_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic [SLOT_BITS-1:0]   idx_reg, idx_next;
    logic [LIMIT_BITS-1:0]  limit_ref_reg, limit_ref_next;
    logic [LIMIT_BITS-1:0]  limit_out_reg, limit_out_next;
    logic [SLOT_BITS-1:0]   slot_step;
    logic                   load;
    lane_ctl_t              lane_ctl;
    logic [SAMPLE_BITS-1:0] ref_hi, ref_lo, out_hi, out_lo;

    assign slot_step = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        in_stall   = 1'b1;
        load       = 1'b0;
        lane_ctl   = '0;
        lane_ctl.wr_slot  = slot_step;
        lane_ctl.scan_idx = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    lane_ctl.wr_en = 1'b1;
                    slot_next      = slot_step;
                    idx_next       = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                lane_ctl.scan_en    = 1'b1;
                lane_ctl.scan_first = (idx_reg == '0);
                idx_next            = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid || !res_stall)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        limit_ref_next = limit_ref_reg;
        limit_out_next = limit_out_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LIMIT_REF: limit_ref_next = cfg_data;
                REG_LIMIT_OUT: limit_out_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            idx_reg       <= '0;
            limit_ref_reg <= LIMIT_RESET;
            limit_out_reg <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            limit_ref_reg <= limit_ref_next;
            limit_out_reg <= limit_out_next;
        end
    end

    dwsd_lane u_lane_ref (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (ref_sample),
        .hi     (ref_hi),
        .lo     (ref_lo)
    );

    dwsd_lane u_lane_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (out_sample),
        .hi     (out_hi),
        .lo     (out_lo)
    );

    dwsd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .ref_hi     (ref_hi),
        .ref_lo     (ref_lo),
        .out_hi     (out_hi),
        .out_lo     (out_lo),
        .limit_ref  (limit_ref_reg),
        .limit_out  (limit_out_reg),
        .res_stall  (res_stall),
        .res_valid  (res_valid),
        .ref_stable (ref_stable),
        .out_stable (out_stable)
    );

endmodule

`default_nettype wire

[src/dwsd_checker.sv]
// Port-level checks for the dual window stability detector, bound to the top.
// Depends on dwsd_pkg and dual_window_stability_detector.
`default_nettype none

module dwsd_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic                                res_valid,
    input  wire logic                                res_stall,
    input  wire logic                                ref_stable,
    input  wire logic                                out_stable
);
    import dwsd_pkg::*;

    logic in_accept;
    assign in_accept = in_valid && !in_stall;

    // a held result keeps its flags
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(ref_stable) && $stable(out_stable))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept and again in the compare step
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall ##WINDOW in_stall)
        else $error("input taken during a scan");

    // a new result only appears out of a busy period
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(in_stall))
        else $error("result without an item in flight");

    // an accept with no result waiting is not followed straight away by a result
    a_no_early_res: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !res_valid |=> !res_valid)
        else $error("result too early after accept");

endmodule

bind dual_window_stability_detector dwsd_checker u_dwsd_checker (.*);

`default_nettype wire

[dv/dual_window_stability_detector_test.sv]
`timescale 1ns / 100ps
// Testbench for dual_window_stability_detector: directed and random items with a scoreboard
// that tracks both sample windows and the two spread limits, under several idling phases.
// Depends on dwsd_pkg and the dual_window_stability_detector RTL.

module dual_window_stability_detector_test;
    import dwsd_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = CFG_INDEX_BITS'(3);
    localparam int PHASE_ITEMS  = 315;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = WINDOW + 4;
    localparam int HOLD_CYCLES  = 80;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [LIMIT_BITS-1:0]  limit_t;
    typedef struct packed {
        logic ref_ok;
        logic out_ok;
    } flag_pair_t;

    localparam sample_t FULL_SCALE = '1;

    // Tracks both channel windows and limits; predicts the stable flags per item.
    class stability_scoreboard;
        sample_t      ref_hist[WINDOW];
        sample_t      out_hist[WINDOW];
        int unsigned  slot;
        limit_t       lim_ref;
        limit_t       lim_out;
        flag_pair_t   expected_flags[$];
        int unsigned  errors;
        int unsigned  checked;

        function new();
            for (int i = 0; i < WINDOW; i++)
            begin
                ref_hist[i] = '0;
                out_hist[i] = '0;
            end
            slot    = 0;
            lim_ref = LIMIT_RESET;
            lim_out = LIMIT_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_limit(logic [CFG_INDEX_BITS-1:0] idx, limit_t value);
            case (idx)
                REG_LIMIT_REF: lim_ref = value;
                REG_LIMIT_OUT: lim_out = value;
                default: ;
            endcase
        endfunction

        function void note_item(sample_t r, sample_t o);
            sample_t    ref_hi, ref_lo, out_hi, out_lo;
            flag_pair_t flags;
            // slot steps before the write, so the first item lands in slot 1
            slot = (slot == WINDOW - 1) ? 0 : slot + 1;
            ref_hist[slot] = r;
            out_hist[slot] = o;
            ref_hi = ref_hist[0];
            ref_lo = ref_hist[0];
            out_hi = out_hist[0];
            out_lo = out_hist[0];
            for (int i = 1; i < WINDOW; i++)
            begin
                if (ref_hist[i] > ref_hi) ref_hi = ref_hist[i];
                if (ref_hist[i] < ref_lo) ref_lo = ref_hist[i];
                if (out_hist[i] > out_hi) out_hi = out_hist[i];
                if (out_hist[i] < out_lo) out_lo = out_hist[i];
            end
            flags.ref_ok = (ref_hi - ref_lo) <= lim_ref;
            flags.out_ok = (out_hi - out_lo) <= lim_out;
            expected_flags.push_back(flags);
        endfunction

        function void check_result(logic rs, logic os);
            flag_pair_t want;
            if (expected_flags.size() == 0)
            begin
                errors++;
                $display("%0t: result ref_stable=%0b out_stable=%0b with no item outstanding",
                         $time, rs, os);
                return;
            end
            want = expected_flags.pop_front();
            checked++;
            if (rs !== want.ref_ok)
            begin
                errors++;
                $display("%0t: ref_stable expected %0b got %0b", $time, want.ref_ok, rs);
            end
            if (os !== want.out_ok)
            begin
                errors++;
                $display("%0t: out_stable expected %0b got %0b", $time, want.out_ok, os);
            end
        endfunction

        function int unsigned outstanding();
            return expected_flags.size();
        endfunction
    endclass

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    logic    in_stall;
    sample_t ref_sample = '0;
    sample_t out_sample = '0;
    logic    res_valid;
    logic    res_stall  = 1'b0;
    logic    ref_stable;
    logic    out_stable;
    logic    cfg_we     = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    limit_t  cfg_data   = '0;

    logic        hold_rx      = 1'b0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned items_sent   = 0;
    int unsigned reg_writes   = 0;
    int unsigned phases       = 0;
    int unsigned idle_cycles  = 0;

    stability_scoreboard sb = new();

    dual_window_stability_detector dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ref_sample (ref_sample),
        .out_sample (out_sample),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .ref_stable (ref_stable),
        .out_stable (out_stable),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        res_stall <= hold_rx || ($urandom_range(0, 99) < rx_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(ref_sample, out_sample);
            if (res_valid && !res_stall)
                sb.check_result(ref_stable, out_stable);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: nothing moved for %0d cycles", $time, idle_cycles);
                $display("dual_window_stability_detector: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(sample_t r, sample_t o);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        ref_sample <= r;
        out_sample <= o;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, limit_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(idx, value);
        reg_writes++;
        @(posedge clk);
    endtask

    // let every outstanding result come back, then wait out the DRAIN_CYCLES margin
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // picks a level and a jitter span; spans near the limit exercise both flag values
    function automatic void new_regime(limit_t lim, output sample_t base, output sample_t amp);
        int unsigned a;
        case ($urandom_range(0, 4))
            0: a = 0;
            1: a = lim;
            2: a = lim + 1;
            3: a = lim / 2;
            default: a = $urandom_range(0, FULL_SCALE);
        endcase
        if (a > FULL_SCALE)
            a = FULL_SCALE;
        amp  = sample_t'(a);
        base = sample_t'($urandom_range(0, FULL_SCALE - a));
    endfunction

    task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct,
                             limit_t lim_r, limit_t lim_o, bit with_hold);
        sample_t base_r, amp_r, base_o, amp_o;
        int n;
        drain();
        write_reg(REG_LIMIT_REF, lim_r);
        write_reg(REG_LIMIT_OUT, lim_o);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        phases++;
        new_regime(lim_r, base_r, amp_r);
        new_regime(lim_o, base_o, amp_o);
        if (with_hold)
        begin
            // receiver holds off while the sender keeps offering, so the block backs up
            fork
                begin
                    hold_rx <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_rx <= 1'b0;
                end
            join_none
        end
        for (n = 0; n < PHASE_ITEMS; n++)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                new_regime(lim_r, base_r, amp_r);
                new_regime(lim_o, base_o, amp_o);
            end
            if ($urandom_range(0, 11) == 0)
                send_item(sample_t'($urandom_range(0, FULL_SCALE)),
                          sample_t'($urandom_range(0, FULL_SCALE)));
            else
                send_item(base_r + sample_t'($urandom_range(0, amp_r)),
                          base_o + sample_t'($urandom_range(0, amp_o)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // writes to unused indexes must leave both limits at their reset value
        write_reg(REG_SPARE_LO, '0);
        write_reg(REG_SPARE_HI, '0);

        // window still all zero: both flags set
        send_item('0, '0);
        // unwritten slots stay zero until every slot has been overwritten
        repeat (8) send_item(FULL_SCALE, FULL_SCALE);
        // spread exactly at the limit, and one past it
        send_item(sample_t'(FULL_SCALE - 16), sample_t'(FULL_SCALE - 17));
        send_item('0, FULL_SCALE);
        send_item(FULL_SCALE, '0);
        send_item(sample_t'(12'hAAA), sample_t'(12'h555));
        send_item(sample_t'(12'h555), sample_t'(12'hAAA));
        send_item(sample_t'(1), sample_t'(2));

        run_phase(0, 0, '0, '1, 1'b0);
        run_phase(71, 0, '1, '0, 1'b0);
        run_phase(0, 71, limit_t'($urandom_range(0, 300)),
                  limit_t'($urandom_range(0, 300)), 1'b0);
        run_phase(21, 21, LIMIT_RESET, limit_t'($urandom_range(0, 64)), 1'b0);
        run_phase(0, 0, limit_t'(1), limit_t'(FULL_SCALE - 1), 1'b1);
        run_phase(21, 21, limit_t'($urandom_range(0, FULL_SCALE)),
                  limit_t'($urandom_range(0, 64)), 1'b0);
        drain();

        $display("covered %0d items in %0d random phases with %0d register writes",
                 items_sent, phases, reg_writes);
        $display("%0d results checked; limits swept from zero to full scale under idling",
                 sb.checked);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("dual_window_stability_detector: match");
        else
            $display("dual_window_stability_detector: mismatch");
        $finish;
    end

endmodule

[files.f]
src/dwsd_pkg.sv
src/dwsd_lane.sv
src/dwsd_merge.sv
src/dual_window_stability_detector.sv
src/dwsd_checker.sv
dv/dual_window_stability_detector_test.sv
